// File: src/acrms_pkg.sv
// shared types, constants and helpers for the ac rms current meter
`timescale 1ns / 1ps
`default_nettype none

package acrms_pkg;

   // default adc resolution
   localparam int ADC_BITS_DEF = 12;

   // register and field widths
   localparam int ZP_W      = 16;
   localparam int TARGET_W  = 8;
   localparam int TICK_W    = 20;
   localparam int SCALE_W   = 16;
   localparam int CSR_W     = 20;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W     = 56;
   localparam int COUNT_W   = 20;
   localparam int RMS_W     = 16;
   localparam int MA_W      = 20;
   localparam int STATUS_W  = 2;
   localparam int OPCODE_W  = 2;

   // q8.8 scale times q.4 rms leaves 12 fraction bits to drop
   localparam int MA_SHIFT = 12;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // saturation limits
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TICK_W-1:0]  TICK_MAX  = '1;

   // register reset values
   localparam logic [ZP_W-1:0]     ZP_RESET      = 16'd32768;
   localparam logic [TARGET_W-1:0] TARGET_RESET  = 8'd1;
   localparam logic [TICK_W-1:0]   TIMEOUT_RESET = 20'd100000;
   localparam logic [SCALE_W-1:0]  SCALE_RESET   = 16'd1690;

   // input opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_START  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_NO_SIGNAL = 2'd1,
      STAT_PARTIAL   = 2'd2
   } status_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_POINT   = 2'd0,
      CSR_CYCLE_TARGET = 2'd1,
      CSR_TIMEOUT      = 2'd2,
      CSR_SCALE        = 2'd3
   } csr_idx_type;

   // configuration register file contents
   typedef struct packed {
      logic [ZP_W-1:0]     zero_point_q4;
      logic [TARGET_W-1:0] cycle_target;
      logic [TICK_W-1:0]   timeout_ticks;
      logic [SCALE_W-1:0]  ma_per_count_q8;
   } cfg_type;

   // launch of one rms computation from the back end
   typedef struct packed {
      logic                go;
      logic [SUM_W-1:0]    sum;
      logic [COUNT_W-1:0]  count;
      status_type          status;
   } rms_req_type;

   // width of the q.4 offset magnitude for a given adc resolution
   function automatic int mag_width(input int adc_bits);
      int w;
      w = adc_bits + 4;
      if (w < ZP_W) begin
         w = ZP_W;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// File: src/acrms_req_if.sv
// request channel interface: opcode and adc sample beats
`timescale 1ns / 1ps
`default_nettype none

interface acrms_req_if import acrms_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output opcode, output adc_sample, input ready);
   modport sink   (input valid, input opcode, input adc_sample, output ready);
endinterface

`default_nettype wire

// File: src/acrms_rsp_if.sv
// response channel interface: rms measurement result beats
`timescale 1ns / 1ps
`default_nettype none

interface acrms_rsp_if import acrms_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RMS_W-1:0]    rms_counts_q4;
   logic [MA_W-1:0]     current_ma;
   logic [COUNT_W-1:0]  sample_total;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output rms_counts_q4, output current_ma,
                   output sample_total, output status, input ready);
   modport sink   (input valid, input rms_counts_q4, input current_ma,
                   input sample_total, input status, output ready);
endinterface

`default_nettype wire

// File: src/acrms_fifo.sv
// small register queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module acrms_fifo import acrms_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // status flags and head of queue
   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/acrms_front.sv
// front end: accepts request beats, drops unknown opcodes, precomputes offsets
`timescale 1ns / 1ps
`default_nettype none

module acrms_front import acrms_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF,
   localparam int MAG_W   = mag_width(ADC_BITS),
   localparam int ENTRY_W = OPCODE_W + 1 + MAG_W
) (
   acrms_req_if.sink          req_ch,
   input  wire cfg_type       cfg,
   input  wire logic          q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data
);

   localparam int ZP_INT_W = ZP_W - 4;
   localparam int CMP_W    = (ADC_BITS > ZP_INT_W) ? ADC_BITS : ZP_INT_W;

   logic             accept;
   logic [MAG_W-1:0] smp_q4, zp_ext, mag;
   logic [CMP_W-1:0] smp_cmp, zp_int;
   logic             below;

   // handshake
   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // q.4 offset magnitude from the zero point
   assign smp_q4 = MAG_W'({req_ch.adc_sample, 4'b0000});
   assign zp_ext = MAG_W'(cfg.zero_point_q4);
   assign mag    = (smp_q4 >= zp_ext) ? (smp_q4 - zp_ext) : (zp_ext - smp_q4);

   // half-wave class against the integer zero point
   assign smp_cmp = CMP_W'(req_ch.adc_sample);
   assign zp_int  = CMP_W'(cfg.zero_point_q4[ZP_W-1:4]);
   assign below   = (smp_cmp < zp_int);

   // only known opcodes go on to the back end
   always_comb begin
      case (op_type'(req_ch.opcode))
         OP_START, OP_SAMPLE, OP_TICK: begin
            q_push = accept;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   assign q_data = {req_ch.opcode, below, mag};

endmodule

`default_nettype wire

// File: src/acrms_core.sv
// back end: sync, accumulation and timeout sequencing of one measurement
`timescale 1ns / 1ps
`default_nettype none

module acrms_core import acrms_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF,
   localparam int MAG_W   = mag_width(ADC_BITS),
   localparam int ENTRY_W = OPCODE_W + 1 + MAG_W
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               q_empty,
   input  wire logic [ENTRY_W-1:0] q_data,
   output logic                    q_pop,
   input  wire logic               rms_idle,
   output rms_req_type             rms_req
);

   localparam int SQ_W = 2 * MAG_W;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BELOW,
      PH_RISE,
      PH_ACC
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TARGET_W-1:0]  cycles_ff, cycles_in;
   logic                 neg_ff, neg_in;
   logic [TICK_W-1:0]    ticks_ff, ticks_in;
   rms_req_type          rms_req_ff, rms_req_in;

   logic [OPCODE_W-1:0]  head_op;
   logic                 head_below;
   logic [MAG_W-1:0]     head_mag;
   logic [SQ_W-1:0]      square;
   logic [SUM_W:0]       sum_add;
   logic [SUM_W-1:0]     sum_sat;
   logic [TARGET_W-1:0]  target;
   logic                 emit;
   status_type           emit_status;

   // queue head fields
   assign {head_op, head_below, head_mag} = q_data;

   // squared offset and saturating sum
   assign square  = head_mag * head_mag;
   assign sum_add = {1'b0, sum_ff} + (SUM_W + 1)'(square);
   assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

   // a zero cycle target counts as one
   assign target = (cfg.cycle_target == '0) ? TARGET_W'(1) : cfg.cycle_target;

   // next measurement state for the beat at the queue head
   always_comb begin
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      cycles_in   = cycles_ff;
      neg_in      = neg_ff;
      ticks_in    = ticks_ff;
      emit        = 1'b0;
      emit_status = STAT_DONE;
      case (op_type'(head_op))
         OP_START: begin
            phase_in  = PH_BELOW;
            sum_in    = '0;
            count_in  = '0;
            cycles_in = '0;
            neg_in    = 1'b0;
            ticks_in  = '0;
         end
         OP_SAMPLE: begin
            case (phase_ff)
               PH_BELOW: begin
                  if (head_below) begin
                     phase_in = PH_RISE;
                  end
               end
               PH_RISE: begin
                  if (!head_below) begin
                     phase_in = PH_ACC;
                  end
               end
               PH_ACC: begin
                  if (count_ff != COUNT_MAX) begin
                     sum_in   = sum_sat;
                     count_in = count_ff + 1'b1;
                  end
                  if (head_below) begin
                     neg_in = 1'b1;
                  end else if (neg_ff) begin
                     neg_in    = 1'b0;
                     cycles_in = cycles_ff + 1'b1;
                     if (cycles_in >= target) begin
                        emit        = 1'b1;
                        emit_status = STAT_DONE;
                        phase_in    = PH_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               if (ticks_ff != TICK_MAX) begin
                  ticks_in = ticks_ff + 1'b1;
               end
               if (ticks_in > cfg.timeout_ticks) begin
                  emit        = 1'b1;
                  emit_status = (phase_ff == PH_ACC) ? STAT_PARTIAL : STAT_NO_SIGNAL;
                  phase_in    = PH_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // a beat that ends a measurement waits until the rms unit is free
   assign q_pop = !q_empty && (!emit || (rms_idle && !rms_req_ff.go));

   // rms launch
   always_comb begin
      rms_req_in        = rms_req_ff;
      rms_req_in.go     = 1'b0;
      if (q_pop && emit) begin
         rms_req_in.go     = 1'b1;
         rms_req_in.sum    = sum_in;
         rms_req_in.count  = count_in;
         rms_req_in.status = emit_status;
      end
   end

   // measurement state and launch register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         sum_ff        <= '0;
         count_ff      <= '0;
         cycles_ff     <= '0;
         neg_ff        <= 1'b0;
         ticks_ff      <= '0;
         rms_req_ff.go <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff  <= phase_in;
            sum_ff    <= sum_in;
            count_ff  <= count_in;
            cycles_ff <= cycles_in;
            neg_ff    <= neg_in;
            ticks_ff  <= ticks_in;
         end
         rms_req_ff <= rms_req_in;
      end
   end

   assign rms_req = rms_req_ff;

endmodule

`default_nettype wire

// File: src/acrms_rms.sv
// rms unit: serial divide, serial square root, scaling and result register
`timescale 1ns / 1ps
`default_nettype none

module acrms_rms import acrms_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire rms_req_type  rms_req,
   output logic              rms_idle,
   acrms_rsp_if.source       rsp_ch
);

   localparam int ROOT_W = SUM_W / 2;
   localparam int RREM_W = ROOT_W + 1;
   localparam int CNT_W  = $clog2(SUM_W);
   localparam int PROD_W = RMS_W + SCALE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_ROOT,
      S_SCALE,
      S_HOLD
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [RREM_W-1:0]   rrem_ff, rrem_in;
   logic [RMS_W-1:0]    rms_ff, rms_in;
   logic [MA_W-1:0]     ma_ff, ma_in;
   status_type          status_ff, status_in;
   logic                out_valid_ff, out_valid_in;
   logic [RMS_W-1:0]    out_rms_ff, out_rms_in;
   logic [MA_W-1:0]     out_ma_ff, out_ma_in;
   logic [COUNT_W-1:0]  out_total_ff, out_total_in;
   status_type          out_status_ff, out_status_in;

   logic [COUNT_W:0]    div_trial;
   logic                div_ge;
   logic [RREM_W+1:0]   root_trial_rem, root_trial;
   logic                root_ge;
   logic [PROD_W-1:0]   prod;
   logic                slot_free;

   // divide step: one quotient bit per cycle
   assign div_trial = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge    = (div_trial >= {1'b0, div_ff});

   // root step: one root bit per cycle, two radicand bits consumed
   assign root_trial_rem = {rrem_ff, quo_ff[SUM_W-1 -: 2]};
   assign root_trial     = (RREM_W + 2)'({root_ff, 2'b01});
   assign root_ge        = (root_trial_rem >= root_trial);

   // q.4 rms times q8.8 scale, 12 fraction bits dropped, fits the ma field
   assign prod = rms_ff * cfg.ma_per_count_q8;

   assign slot_free = !out_valid_ff || rsp_ch.ready;
   assign rms_idle  = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      root_in       = root_ff;
      rrem_in       = rrem_ff;
      rms_in        = rms_ff;
      ma_in         = ma_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_rms_in    = out_rms_ff;
      out_ma_in     = out_ma_ff;
      out_total_in  = out_total_ff;
      out_status_in = out_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (rms_req.go) begin
               quo_in    = rms_req.sum;
               rem_in    = '0;
               div_in    = rms_req.count;
               status_in = rms_req.status;
               cnt_in    = CNT_W'(SUM_W - 1);
               if (rms_req.count == '0) begin
                  rms_in   = '0;
                  state_in = S_SCALE;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_ge) begin
               rem_in = COUNT_W'(div_trial - {1'b0, div_ff});
            end else begin
               rem_in = div_trial[COUNT_W-1:0];
            end
            quo_in = {quo_ff[SUM_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               root_in  = '0;
               rrem_in  = '0;
               cnt_in   = CNT_W'(ROOT_W - 1);
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_ge) begin
               rrem_in = RREM_W'(root_trial_rem - root_trial);
            end else begin
               rrem_in = root_trial_rem[RREM_W-1:0];
            end
            root_in = {root_ff[ROOT_W-2:0], root_ge};
            quo_in  = {quo_ff[SUM_W-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rms_in   = (|root_in[ROOT_W-1:RMS_W]) ? '1 : root_in[RMS_W-1:0];
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            ma_in    = MA_W'(prod[PROD_W-1:MA_SHIFT]);
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_rms_in    = rms_ff;
               out_ma_in     = ma_ff;
               out_total_in  = div_ff;
               out_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff        <= cnt_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      root_ff       <= root_in;
      rrem_ff       <= rrem_in;
      rms_ff        <= rms_in;
      ma_ff         <= ma_in;
      status_ff     <= status_in;
      out_rms_ff    <= out_rms_in;
      out_ma_ff     <= out_ma_in;
      out_total_ff  <= out_total_in;
      out_status_ff <= out_status_in;
   end

   // response channel
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.rms_counts_q4 = out_rms_ff;
   assign rsp_ch.current_ma    = out_ma_ff;
   assign rsp_ch.sample_total  = out_total_ff;
   assign rsp_ch.status        = out_status_ff;

endmodule

`default_nettype wire

// File: src/ac_rms_current_meter.sv
// top level of the ac rms current meter
// Usage: beats on req_ch carry an opcode (start, adc sample, tick) and a sample.
// A start beat arms a measurement; samples sync to a rising zero crossing, then
// squared offsets are summed until cycle_target cycles are seen. Ticks drive the
// timeout. One beat on rsp_ch carries each finished measurement.
// Throughput: one request beat per cycle while the queue is not full; a four-entry
// queue parts the front end from the back end, which takes one beat per cycle from
// the queue unless a beat that ends a measurement waits for the rms unit.
// Result path: the beat that ends a measurement passes the queue and the launch
// register, then serial division, serial square root, scaling and the output
// register in the rms unit. Results with no samples skip the division and root.
// While the rms unit is busy, request beats are still taken; a beat that would
// end a further measurement waits at the queue head until the unit is free.
// A stalled receiver holds the result in the output register; a following
// result waits inside the rms unit, and the queue then fills and drops ready.
// Reset is synchronous and active high: the meter goes idle, the queue empties
// and all csr registers return to their defaults. Csr writes take effect at
// once and are meant for idle periods.
`timescale 1ns / 1ps
`default_nettype none

module ac_rms_current_meter import acrms_pkg::*; #(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   acrms_req_if.sink                 req_ch,
   acrms_rsp_if.source               rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wr_data
);

   localparam int MAG_W   = mag_width(ADC_BITS);
   localparam int ENTRY_W = OPCODE_W + 1 + MAG_W;

   cfg_type             cfg_ff, cfg_in;
   logic                q_push, q_full, q_pop, q_empty;
   logic [ENTRY_W-1:0]  q_push_data, q_pop_data;
   logic                rms_idle;
   rms_req_type         rms_req;

   // csr write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_ZERO_POINT: begin
               cfg_in.zero_point_q4 = csr_wr_data[ZP_W-1:0];
            end
            CSR_CYCLE_TARGET: begin
               cfg_in.cycle_target = csr_wr_data[TARGET_W-1:0];
            end
            CSR_TIMEOUT: begin
               cfg_in.timeout_ticks = csr_wr_data[TICK_W-1:0];
            end
            CSR_SCALE: begin
               cfg_in.ma_per_count_q8 = csr_wr_data[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_point_q4   <= ZP_RESET;
         cfg_ff.cycle_target    <= TARGET_RESET;
         cfg_ff.timeout_ticks   <= TIMEOUT_RESET;
         cfg_ff.ma_per_count_q8 <= SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end
   acrms_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .req_ch (req_ch),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   // queue between front and back
   acrms_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // back end sequencing
   acrms_core #(
      .ADC_BITS (ADC_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rms_idle (rms_idle),
      .rms_req  (rms_req)
   );

   // rms computation and result register
   acrms_rms u_rms (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .rms_req  (rms_req),
      .rms_idle (rms_idle),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the ac rms current meter: directed and random beats
`timescale 1ns / 1ps

module testbench;
   import acrms_pkg::*;

   localparam int CLK_HALF     = 2;
   localparam int RESET_CYCLES = 9;
   // settle time that covers division and root in the back end
   localparam int DRAIN_CYCLES = 100;
   localparam int FINAL_WAIT   = 5000;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SMP_W        = ADC_BITS_DEF;
   localparam int ZP_INT_W     = ZP_W - 4;

   // opcode value the meter has no use for
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [RMS_W-1:0]    RMS_MAX   = '1;
   localparam logic [MA_W-1:0]     MA_MAX    = '1;
   localparam logic [SMP_W-1:0]    SMP_MAX   = '1;

   typedef enum logic [1:0] {
      MTR_IDLE,
      MTR_WAIT_LOW,
      MTR_WAIT_RISE,
      MTR_ACCUM
   } mtr_state_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN
   } stall_mode_type;

   typedef struct {
      logic [RMS_W-1:0]   rms_q4;
      logic [MA_W-1:0]    milliamps;
      logic [COUNT_W-1:0] samples;
      status_type         status;
   } reading_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;

   acrms_req_if #(.ADC_BITS(ADC_BITS_DEF)) req_ch ();
   acrms_rsp_if rsp_ch ();

   ac_rms_current_meter #(.ADC_BITS(ADC_BITS_DEF)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // mirror of the meter registers and measurement state
   logic [ZP_W-1:0]     cfg_zero_q4;
   logic [TARGET_W-1:0] cfg_target;
   logic [TICK_W-1:0]   cfg_timeout;
   logic [SCALE_W-1:0]  cfg_scale;
   mtr_state_type       mtr_state;
   logic [SUM_W-1:0]    sq_sum;
   logic [COUNT_W-1:0]  sample_cnt;
   logic [TARGET_W-1:0] cycle_cnt;
   logic                low_half;
   logic [TICK_W-1:0]   tick_cnt;

   reading_type pending_readings[$];

   int             error_count   = 0;
   int             beats_sent    = 0;
   int             live_beats    = 0;
   int             readings_seen = 0;
   int             config_count  = 0;
   int             cycle_count   = 0;
   int             status_seen[3] = '{0, 0, 0};
   int             burst_left    = 0;
   bit             gaps_on       = 1'b1;
   stall_mode_type stall_mode    = STALL_RANDOM;
   logic [15:0]    stall_pattern = 16'h00FF;
   logic [3:0]     stall_phase   = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // integer square root, one result bit per step from the top
   function automatic logic [31:0] int_sqrt(input logic [63:0] value);
      logic [31:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = {32'd0, root | (32'd1 << b)};
         if (trial * trial <= value) root = trial[31:0];
      end
      return root;
   endfunction

   function automatic void clear_meter();
      sq_sum     = '0;
      sample_cnt = '0;
      cycle_cnt  = '0;
      low_half   = 1'b0;
      tick_cnt   = '0;
   endfunction

   function automatic void reset_meter_model();
      cfg_zero_q4 = ZP_RESET;
      cfg_target  = TARGET_RESET;
      cfg_timeout = TIMEOUT_RESET;
      cfg_scale   = SCALE_RESET;
      mtr_state   = MTR_IDLE;
      clear_meter();
   endfunction

   // rms of the samples gathered so far, scaled to milliamps
   function automatic reading_type rms_reading(input status_type st);
      reading_type r;
      logic [63:0] mean_sq;
      logic [63:0] root;
      logic [63:0] ma;
      root = '0;
      if (sample_cnt != 0) begin
         mean_sq = {8'd0, sq_sum} / {44'd0, sample_cnt};
         root    = {32'd0, int_sqrt(mean_sq)};
      end
      if (root > 64'(RMS_MAX)) root = 64'(RMS_MAX);
      ma = (root * 64'(cfg_scale)) >> MA_SHIFT;
      if (ma > 64'(MA_MAX)) ma = 64'(MA_MAX);
      r.rms_q4    = root[RMS_W-1:0];
      r.milliamps = ma[MA_W-1:0];
      r.samples   = sample_cnt;
      r.status    = st;
      return r;
   endfunction

   // advance the mirror by one accepted beat; returns 0 for a beat the meter ignores
   function automatic bit predict_beat(input logic [OPCODE_W-1:0] op,
                                       input logic [SMP_W-1:0] smp);
      logic [ZP_INT_W-1:0] zp_int;
      logic [TARGET_W-1:0] target;
      int                  offset;
      logic [63:0]         mag;
      logic [63:0]         sq;
      reading_type         r;
      zp_int = cfg_zero_q4[ZP_W-1:4];
      target = (cfg_target == 0) ? 8'd1 : cfg_target;
      if (op == OP_UNUSED || (op != OP_START && mtr_state == MTR_IDLE)) return 1'b0;
      case (op)
         OP_START: begin
            clear_meter();
            mtr_state = MTR_WAIT_LOW;
         end
         OP_SAMPLE: begin
            case (mtr_state)
               MTR_WAIT_LOW: begin
                  if (smp < zp_int) mtr_state = MTR_WAIT_RISE;
               end
               MTR_WAIT_RISE: begin
                  // the sample that completes sync is not summed
                  if (smp >= zp_int) mtr_state = MTR_ACCUM;
               end
               default: begin
                  // full counter stops the sum but not crossing detection
                  if (sample_cnt != COUNT_MAX) begin
                     offset = int'(smp) * 16 - int'(cfg_zero_q4);
                     mag    = 64'((offset < 0) ? -offset : offset);
                     sq     = mag * mag;
                     if ({8'd0, sq_sum} > {8'd0, SUM_MAX} - sq) sq_sum = SUM_MAX;
                     else sq_sum = sq_sum + sq[SUM_W-1:0];
                     sample_cnt = sample_cnt + 1'b1;
                  end
                  if (smp < zp_int) begin
                     low_half = 1'b1;
                  end else if (low_half) begin
                     low_half  = 1'b0;
                     cycle_cnt = cycle_cnt + 1'b1;
                     if (cycle_cnt >= target) begin
                        pending_readings.push_back(rms_reading(STAT_DONE));
                        mtr_state = MTR_IDLE;
                     end
                  end
               end
            endcase
         end
         OP_TICK: begin
            if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt > cfg_timeout) begin
               if (mtr_state == MTR_ACCUM) begin
                  r = rms_reading(STAT_PARTIAL);
               end else begin
                  r.rms_q4    = '0;
                  r.milliamps = '0;
                  r.samples   = '0;
                  r.status    = STAT_NO_SIGNAL;
               end
               pending_readings.push_back(r);
               mtr_state = MTR_IDLE;
            end
         end
         default: begin
         end
      endcase
      return 1'b1;
   endfunction

   // send one request beat, with a random gap at the start of each burst when gaps are on
   task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [SMP_W-1:0] smp);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
         end
      end
      if (gap > 0) begin
         req_ch.valid      <= 1'b0;
         req_ch.opcode     <= OPCODE_W'($urandom_range(0, 3));
         req_ch.adc_sample <= SMP_W'($urandom_range(0, 4095));
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.adc_sample <= smp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      if (predict_beat(op, smp)) live_beats++;
   endtask

   // hold the sender until every expected reading is back, then settle
   task automatic await_readings(input int settle);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_readings.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_W-1:0] word);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= word;
      @(posedge clock);
      case (idx)
         CSR_ZERO_POINT:   cfg_zero_q4 = word[ZP_W-1:0];
         CSR_CYCLE_TARGET: cfg_target  = word[TARGET_W-1:0];
         CSR_TIMEOUT:      cfg_timeout = word[TICK_W-1:0];
         CSR_SCALE:        cfg_scale   = word[SCALE_W-1:0];
         default: begin
         end
      endcase
   endtask

   // reprogram all registers once the meter has gone quiet; spare upper bits are junk
   task automatic set_config(input logic [ZP_W-1:0] zp, input logic [TARGET_W-1:0] target,
                             input logic [TICK_W-1:0] timeout, input logic [SCALE_W-1:0] scale);
      logic [11:0] junk;
      junk = 12'($urandom);
      await_readings(DRAIN_CYCLES);
      write_reg(CSR_ZERO_POINT, {junk[3:0], zp});
      write_reg(CSR_CYCLE_TARGET, {junk, target});
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_SCALE, {junk[11:8], scale});
      csr_wr_en <= 1'b0;
      config_count++;
   endtask

   // a sample below the integer zero point, or any sample when none is below
   function automatic logic [SMP_W-1:0] low_level();
      logic [ZP_INT_W-1:0] zp_int;
      zp_int = cfg_zero_q4[ZP_W-1:4];
      if (zp_int == 0) return SMP_W'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0) return zp_int - 1'b1;
      return SMP_W'($urandom_range(0, zp_int - 1));
   endfunction

   // a sample at or above the integer zero point
   function automatic logic [SMP_W-1:0] high_level();
      logic [ZP_INT_W-1:0] zp_int;
      zp_int = cfg_zero_q4[ZP_W-1:4];
      if ($urandom_range(0, 3) == 0) return zp_int;
      return SMP_W'($urandom_range(zp_int, SMP_MAX));
   endfunction

   // start, then a square-ish wave of random half cycles with ticks mixed in
   task automatic send_waveform();
      int halves;
      int len;
      bit low;
      send_beat(OP_START, SMP_W'($urandom_range(0, 4095)));
      halves = $urandom_range(1, (cfg_target > 10) ? 24 : 2 * cfg_target + 4);
      low    = 1'($urandom_range(0, 1));
      repeat (halves) begin
         len = $urandom_range(1, 6);
         repeat (len) begin
            if ($urandom_range(0, 5) == 0) begin
               send_beat(OP_TICK, SMP_W'($urandom_range(0, 4095)));
            end
            send_beat(OP_SAMPLE, low ? low_level() : high_level());
         end
         low = !low;
      end
   endtask

   // start with no dip below zero, so sync never happens; the ticks sent may reach the timeout
   task automatic send_dead_line();
      int ticks;
      send_beat(OP_START, SMP_W'($urandom_range(0, 4095)));
      ticks = (cfg_timeout < 40) ? int'(cfg_timeout) + 1 : 40;
      ticks = $urandom_range(1, ticks);
      repeat (ticks) begin
         if ($urandom_range(0, 1) == 0) send_beat(OP_SAMPLE, high_level());
         send_beat(OP_TICK, SMP_W'($urandom_range(0, 4095)));
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 8)) begin
         send_beat(OPCODE_W'($urandom_range(0, 3)), SMP_W'($urandom_range(0, 4095)));
      end
   endtask

   // ignored beats on an idle meter, then one full cycle at reset settings
   task automatic test_idle_and_full_cycle();
      send_beat(OP_SAMPLE, 12'd1234);
      send_beat(OP_TICK, 12'd0);
      send_beat(OP_UNUSED, 12'hFFF);
      send_beat(OP_START, 12'd0);
      send_beat(OP_SAMPLE, 12'hFFF);
      send_beat(OP_SAMPLE, 12'd0);
      // exactly at zero point completes sync
      send_beat(OP_SAMPLE, 12'd2048);
      send_beat(OP_SAMPLE, 12'd0);
      send_beat(OP_SAMPLE, 12'd3000);
   endtask

   // no-signal timeout, restart mid-run, partial results with and without data
   task automatic test_timeout_paths();
      set_config(16'hFFFF, 8'd0, 20'd1, 16'hFFFF);
      send_beat(OP_START, 12'd0);
      send_beat(OP_TICK, 12'd0);
      send_beat(OP_TICK, 12'd0);
      send_beat(OP_START, 12'd0);
      send_beat(OP_SAMPLE, 12'd0);
      send_beat(OP_SAMPLE, 12'hFFF);
      send_beat(OP_SAMPLE, 12'd7);
      send_beat(OP_START, 12'd0);
      send_beat(OP_SAMPLE, 12'd0);
      send_beat(OP_SAMPLE, 12'hFFF);
      send_beat(OP_TICK, 12'd0);
      send_beat(OP_TICK, 12'd0);
      send_beat(OP_START, 12'd0);
      send_beat(OP_SAMPLE, 12'd0);
      send_beat(OP_SAMPLE, 12'hFFF);
      send_beat(OP_SAMPLE, 12'hFFF);
      send_beat(OP_SAMPLE, 12'd100);
      send_beat(OP_TICK, 12'd0);
      send_beat(OP_TICK, 12'd0);
   endtask

   // random measurements under a series of register settings
   task automatic test_random_measurements();
      int quota;
      int first_live;
      int pick;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_config(16'h0000, 8'd255, TICK_MAX, 16'h0000);
            1: set_config(16'hFFFF, 8'd0, 20'd1, 16'hFFFF);
            default: set_config(ZP_W'($urandom_range(100 * 16, 3995 * 16)),
                                TARGET_W'(($urandom_range(0, 4) == 0) ?
                                          $urandom_range(5, 40) : $urandom_range(1, 4)),
                                TICK_W'($urandom_range(3, 60)),
                                SCALE_W'($urandom_range(0, 65535)));
         endcase
         gaps_on       = (p % 3 != 2);
         stall_mode    = (p % 3 == 0) ? STALL_PATTERN :
                         (p % 3 == 1) ? STALL_RANDOM : STALL_NONE;
         stall_pattern = 16'($urandom) | 16'h0001;
         quota         = (p == 0) ? 40 : 130;
         first_live    = live_beats;
         while (live_beats - first_live < quota) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) await_readings(0);
            else if (pick < 3) send_dead_line();
            else if (pick < 6) send_noise();
            else send_waveform();
         end
      end
   endtask

   // receiver ready pattern
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_mode)
         STALL_NONE:   rsp_ch.ready <= 1'b1;
         STALL_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default:      rsp_ch.ready <= stall_pattern[stall_phase];
      endcase
   end

   // compare each result beat with the oldest expected reading
   always @(posedge clock) begin : check_beat
      reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         readings_seen++;
         if (pending_readings.size() == 0) begin
            $error("unexpected result: rms_counts_q4=%0d current_ma=%0d status=%0d",
                   rsp_ch.rms_counts_q4, rsp_ch.current_ma, rsp_ch.status);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            status_seen[want.status]++;
            if (rsp_ch.rms_counts_q4 !== want.rms_q4) begin
               $error("rms_counts_q4: expected %0d, actual %0d", want.rms_q4,
                      rsp_ch.rms_counts_q4);
               error_count++;
            end
            if (rsp_ch.current_ma !== want.milliamps) begin
               $error("current_ma: expected %0d, actual %0d", want.milliamps,
                      rsp_ch.current_ma);
               error_count++;
            end
            if (rsp_ch.sample_total !== want.samples) begin
               $error("sample_total: expected %0d, actual %0d", want.samples,
                      rsp_ch.sample_total);
               error_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
                  pending_readings.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : main
      int waited;
      req_ch.valid      <= 1'b0;
      req_ch.opcode     <= OP_START;
      req_ch.adc_sample <= '0;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_ZERO_POINT;
      csr_wr_data       <= '0;
      reset             <= 1'b1;
      reset_meter_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_full_cycle();
      test_timeout_paths();
      test_random_measurements();

      // let the last readings come back, then watch for strays
      req_ch.valid <= 1'b0;
      waited = 0;
      while (pending_readings.size() != 0 && waited < FINAL_WAIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_readings.size() != 0) begin
         $error("%0d expected readings never arrived", pending_readings.size());
         error_count++;
      end

      $display("sent %0d request beats (%0d not ignored) across %0d register settings",
               beats_sent, live_beats, config_count);
      $display("checked %0d readings: %0d complete, %0d no signal, %0d partial",
               readings_seen, status_seen[STAT_DONE], status_seen[STAT_NO_SIGNAL],
               status_seen[STAT_PARTIAL]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
